[src/sspd_pkg.sv]
// Package for the six-axis serial packet decoder.
// Holds the packet codes, result codes and the parity check tables.
// No dependencies.
`default_nettype none

package sspd_pkg;

  localparam int PACKET_BYTES_DEF = 16;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [7:0] HEAD_DISP   = 8'h64;
  localparam logic [7:0] HEAD_BUTTON = 8'h6B;
  localparam logic [7:0] HEAD_MODE   = 8'h63;
  localparam logic [7:0] HEAD_RADIUS = 8'h6E;
  localparam logic [7:0] HEAD_SCALE  = 8'h71;

  localparam int LEN_DISP   = 15;
  localparam int LEN_BUTTON = 4;
  localparam int LEN_MODE   = 3;
  localparam int LEN_RADIUS = 2;
  localparam int LEN_SCALE  = 3;

  localparam int IDX_LAST_PAIR = 12;
  localparam int IDX_CHECKSUM  = 14;

  typedef enum logic [2:0] {
    KIND_DISP    = 3'd0,
    KIND_BUTTON  = 3'd1,
    KIND_MODE    = 3'd2,
    KIND_RADIUS  = 3'd3,
    KIND_SCALE   = 3'd4,
    KIND_UNKNOWN = 3'd5,
    KIND_OVERRUN = 3'd6
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD_A = 2'd1;
  localparam logic [1:0] ST_BAD_B = 2'd2;
  localparam logic [1:0] ST_CHK   = 2'd3;

  localparam logic [7:0] HI_NIBBLE_CHECK [16] = '{
    8'hE0, 8'hA0, 8'hA0, 8'h60, 8'hA0, 8'h60, 8'h60, 8'hA0,
    8'h90, 8'h50, 8'h50, 8'h90, 8'hD0, 8'h90, 8'h90, 8'h50
  };

  localparam logic [7:0] TOP_PAIR_CHECK [64] = '{
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h40, 8'h80, 8'hC0, 8'h80, 8'h80, 8'h40,
    8'hC0, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h00, 8'h80
  };

  typedef struct packed {
    logic               a_ok;
    logic               b_ok;
    logic signed [10:0] axis;
    logic [5:0]         inc;
  } pair_res_t;

endpackage

`default_nettype wire

[src/sspd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sspd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/sspd_pair_dec.sv]
// Decoder for one axis byte pair: parity checks, axis value and checksum term.
// Depends on sspd_pkg for the check tables and the result struct.
`default_nettype none

module sspd_pair_dec (
  input  wire logic [7:0]         a_byte,
  input  wire logic [7:0]         b_byte,
  output sspd_pkg::pair_res_t     res
);
  import sspd_pkg::*;

  logic [9:0]         code;
  logic signed [10:0] axis;
  logic signed [10:0] shr;

  assign code = {a_byte[3:0], b_byte[5:0]};
  assign axis = (code > 10'd512) ? {1'b1, code} : {1'b0, code};
  assign shr  = axis >>> 6;

  assign res.a_ok = ({a_byte[7:4], 4'h0} == HI_NIBBLE_CHECK[a_byte[3:0]]);
  assign res.b_ok = ({b_byte[7:6], 6'h00} == TOP_PAIR_CHECK[b_byte[5:0]]);
  assign res.axis = axis;
  assign res.inc  = axis[5:0] + shr[5:0];

endmodule

`default_nettype wire

[src/six_axis_serial_packet_decoder.sv]
// Six-axis serial packet decoder: collects received bytes and decodes packets.
// Depends on sspd_pkg, sspd_ram and sspd_pair_dec.
//
// Input channel: rx_byte with in_valid/in_stall. Output channel: kind, status,
// axis_0..axis_5 and info with out_valid/out_stall. A transaction happens at
// a clock edge where valid is high and stall is low.
// Ordinary bytes are written into the packet RAM at one per cycle while in_stall
// is low and give no result. A newline starts a decode pass that reads RAM entries
// 0 to 14 one per cycle through the single read port, so the block holds in_stall
// through the READ, TAIL and DONE states after a newline, and the result is loaded
// into the output register from the DONE state. A byte that fills the store
// gives an overrun result through the DONE state and stalls the input while
// that state waits. One packet is decoded at a time.
// The output register holds one result; a new byte is accepted while it
// waits. When the receiver stalls, a finished decode waits in its final
// state and the input stays stalled until the register frees up.
// Reset clears the fill position, the sequencer and the output valid; the
// RAM is not cleared, since only entries written in the current packet are
// ever used.
`default_nettype none

module six_axis_serial_packet_decoder #(
  parameter int PACKET_BYTES = sspd_pkg::PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              kind,
  output logic [1:0]              status,
  output logic signed [10:0]      axis_0,
  output logic signed [10:0]      axis_1,
  output logic signed [10:0]      axis_2,
  output logic signed [10:0]      axis_3,
  output logic signed [10:0]      axis_4,
  output logic signed [10:0]      axis_5,
  output logic [10:0]             info
);
  import sspd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_TAIL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state;
  logic [AW-1:0]      fill;
  logic [AW-1:0]      cnt;
  logic               ovf;
  logic               proc_vld;
  logic [AW-1:0]      proc_idx;
  logic [7:0]         rdata;
  logic [7:0]         head;
  logic [7:0]         b1;
  logic [7:0]         b2;
  logic [7:0]         b3;
  logic [7:0]         a_hold;
  logic [5:0]         chk6;
  logic [1:0]         err;
  logic [5:0]         acc;
  logic signed [10:0] axes [6];
  pair_res_t          pair;
  logic [2:0]         pk;
  logic               in_take;
  logic               is_nl;
  logic               load;
  kind_t              kind_next;
  logic [1:0]         status_next;
  logic [10:0]        info_next;
  logic               ax_en;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign is_nl    = (rx_byte == NEWLINE_BYTE);
  assign load     = (state == S_DONE) && (!out_valid || !out_stall);
  assign pk       = proc_idx[3:1] - 3'd1;

  sspd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (in_take && !is_nl),
    .waddr (fill),
    .wdata (rx_byte),
    .raddr (cnt),
    .rdata (rdata)
  );

  sspd_pair_dec u_pair (
    .a_byte (a_hold),
    .b_byte (rdata),
    .res    (pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= (state == S_READ);
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (is_nl) begin
              state <= S_READ;
              cnt   <= '0;
              ovf   <= 1'b0;
            end else if (fill == AW'(PACKET_BYTES - 1)) begin
              state <= S_DONE;
              fill  <= '0;
              ovf   <= 1'b1;
            end else begin
              fill <= fill + AW'(1);
            end
          end
        end
        S_READ: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(IDX_CHECKSUM)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
            fill  <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= cnt;
    if (in_take && is_nl) begin
      err <= ST_OK;
      acc <= '0;
    end
    if (proc_vld) begin
      if (proc_idx == '0) begin
        head <= rdata;
      end
      if (proc_idx == AW'(1)) begin
        b1 <= rdata;
      end
      if (proc_idx == AW'(2)) begin
        b2 <= rdata;
      end
      if (proc_idx == AW'(3)) begin
        b3 <= rdata;
      end
      if (proc_idx == AW'(IDX_CHECKSUM)) begin
        chk6 <= rdata[5:0];
      end
      if (proc_idx[0]) begin
        a_hold <= rdata;
      end
      if (!proc_idx[0] && proc_idx != '0 && proc_idx <= AW'(IDX_LAST_PAIR)) begin
        axes[pk] <= pair.axis;
        acc      <= acc + pair.inc;
        if (err == ST_OK) begin
          if (!pair.a_ok) begin
            err <= ST_BAD_A;
          end else if (!pair.b_ok) begin
            err <= ST_BAD_B;
          end
        end
      end
    end
  end

  always_comb begin
    kind_next   = KIND_UNKNOWN;
    status_next = ST_OK;
    info_next   = '0;
    ax_en       = 1'b0;
    if (ovf) begin
      kind_next = KIND_OVERRUN;
    end else if (head == HEAD_DISP && fill == AW'(LEN_DISP)) begin
      kind_next = KIND_DISP;
      if (err != ST_OK) begin
        status_next = err;
      end else begin
        ax_en       = 1'b1;
        status_next = (acc == chk6) ? ST_OK : ST_CHK;
      end
    end else if (head == HEAD_BUTTON && fill == AW'(LEN_BUTTON)) begin
      kind_next = KIND_BUTTON;
      info_next = {b3[2:0], b2[3:0], b1[3:0]};
    end else if (head == HEAD_MODE && fill == AW'(LEN_MODE)) begin
      kind_next = KIND_MODE;
      info_next = {8'h00, b1[2:0]};
    end else if (head == HEAD_RADIUS && fill == AW'(LEN_RADIUS)) begin
      kind_next = KIND_RADIUS;
      info_next = {7'h00, b1[3:0]};
    end else if (head == HEAD_SCALE && fill == AW'(LEN_SCALE)) begin
      kind_next = KIND_SCALE;
      info_next = {5'h00, b2[2:0], b1[2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind   <= kind_next;
      status <= status_next;
      info   <= info_next;
      axis_0 <= ax_en ? axes[0] : '0;
      axis_1 <= ax_en ? axes[1] : '0;
      axis_2 <= ax_en ? axes[2] : '0;
      axis_3 <= ax_en ? axes[3] : '0;
      axis_4 <= ax_en ? axes[4] : '0;
      axis_5 <= ax_en ? axes[5] : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_newline_starts_read: assert property (@(posedge clk) disable iff (rst)
    in_take && is_nl |=> state == S_READ && cnt == '0)
    else $error("newline transaction did not start a decode pass");

  a_overrun_wraps: assert property (@(posedge clk) disable iff (rst)
    in_take && !is_nl && fill == AW'(PACKET_BYTES - 1) |=> state == S_DONE && ovf && fill == '0)
    else $error("full store did not raise an overrun");

  a_status_disp_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DISP |-> status == ST_OK)
    else $error("nonzero status on a non-displacement result");

  a_parity_zero_axes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD_A || status == ST_BAD_B) |->
      axis_0 == '0 && axis_1 == '0 && axis_2 == '0 &&
      axis_3 == '0 && axis_4 == '0 && axis_5 == '0)
    else $error("axes not zero after a parity failure");
`endif

endmodule

`default_nettype wire

[verif/sspd_report_checker.sv]
`timescale 1ns / 100ps
// Report checker for the six-axis serial packet decoder testbench.
// Watches both channels, predicts each report from the accepted bytes and compares.
// Depends on sspd_pkg.

module sspd_report_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         kind,
  input  logic [1:0]         status,
  input  logic signed [10:0] axis_0,
  input  logic signed [10:0] axis_1,
  input  logic signed [10:0] axis_2,
  input  logic signed [10:0] axis_3,
  input  logic signed [10:0] axis_4,
  input  logic signed [10:0] axis_5,
  input  logic [10:0]        info,
  output int                 error_count,
  output int                 pending,
  output int                 report_count
);
  import sspd_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       status;
    logic [5:0][10:0] axes;
    logic [10:0]      info;
  } report_t;

  logic [7:0]       held [PACKET_BYTES_DEF];
  int               fill;
  report_t          expected_reports [$];
  report_t          fresh;
  logic [5:0][10:0] seen_axes;

  assign seen_axes = {axis_5, axis_4, axis_3, axis_2, axis_1, axis_0};

  function automatic report_t decode_motion();
    report_t    r;
    logic [7:0] a;
    logic [7:0] b;
    logic [5:0] chk;
    int         n;
    int         total;
    int         adj;
    r = '0;
    r.kind = KIND_DISP;
    total = 0;
    adj = 0;
    for (int k = 0; k < 6; k++) begin
      a = held[1 + 2 * k];
      b = held[2 + 2 * k];
      if ((a & 8'hF0) != HI_NIBBLE_CHECK[a[3:0]]) begin
        r.status = ST_BAD_A;
        r.axes = '0;
        return r;
      end
      if ((b & 8'hC0) != TOP_PAIR_CHECK[b[5:0]]) begin
        r.status = ST_BAD_B;
        r.axes = '0;
        return r;
      end
      n = int'({a[3:0], b[5:0]});
      if (n > 512) n -= 1024;
      r.axes[k] = n[10:0];
      total += n;
      adj += (n < 0) ? -1 - ((-(n + 1)) / 64) : n / 64;
    end
    chk = total[5:0] + adj[5:0];
    r.status = (chk == held[IDX_CHECKSUM][5:0]) ? ST_OK : ST_CHK;
    return r;
  endfunction

  function automatic bit take_byte(input logic [7:0] b, output report_t r);
    logic [7:0] head;
    r = '0;
    if (b != NEWLINE_BYTE) begin
      held[fill] = b;
      fill++;
      if (fill == PACKET_BYTES_DEF) begin
        fill = 0;
        r.kind = KIND_OVERRUN;
        return 1'b1;
      end
      return 1'b0;
    end
    head = (fill > 0) ? held[0] : 8'h00;
    if (head == HEAD_DISP && fill == LEN_DISP) begin
      r = decode_motion();
    end else if (head == HEAD_BUTTON && fill == LEN_BUTTON) begin
      r.kind = KIND_BUTTON;
      r.info = {held[3][2:0], held[2][3:0], held[1][3:0]};
    end else if (head == HEAD_MODE && fill == LEN_MODE) begin
      r.kind = KIND_MODE;
      r.info = {8'h00, held[1][2:0]};
    end else if (head == HEAD_RADIUS && fill == LEN_RADIUS) begin
      r.kind = KIND_RADIUS;
      r.info = {7'h00, held[1][3:0]};
    end else if (head == HEAD_SCALE && fill == LEN_SCALE) begin
      r.kind = KIND_SCALE;
      r.info = {5'h00, held[2][2:0], held[1][2:0]};
    end else begin
      r.kind = KIND_UNKNOWN;
    end
    fill = 0;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report, expected none, actual kind %0d", $time, kind);
      error_count++;
      return;
    end
    want = expected_reports.pop_front();
    report_count++;
    compare_field("kind", int'(want.kind), int'(kind));
    compare_field("status", int'(want.status), int'(status));
    for (int k = 0; k < 6; k++)
      compare_field($sformatf("axis_%0d", k), int'($signed(want.axes[k])),
                    int'($signed(seen_axes[k])));
    compare_field("info", int'(want.info), int'(info));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_reports.delete();
      error_count = 0;
      report_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) check_report();
      if (in_valid && !in_stall) begin
        if (take_byte(rx_byte, fresh)) expected_reports.push_back(fresh);
      end
      pending <= expected_reports.size();
    end
  end

endmodule

[verif/six_axis_serial_packet_decoder_tb.sv]
`timescale 1ns / 100ps
// Top of the six-axis serial packet decoder testbench: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on sspd_pkg, the decoder and sspd_report_checker.

module six_axis_serial_packet_decoder_tb;
  import sspd_pkg::*;

  localparam int BYTE_TARGET = 1050;
  localparam int CYCLE_LIMIT = 500000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         kind;
  logic [1:0]         status;
  logic signed [10:0] axis_0;
  logic signed [10:0] axis_1;
  logic signed [10:0] axis_2;
  logic signed [10:0] axis_3;
  logic signed [10:0] axis_4;
  logic signed [10:0] axis_5;
  logic [10:0]        info;
  int                 error_count;
  int                 pending;
  int                 report_count;

  logic       quiet = 1'b0;
  int         stall_left = 0;
  int         stall_roll;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         axis_pick [6];
  logic [7:0] frame [$];

  six_axis_serial_packet_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status),
    .axis_0(axis_0), .axis_1(axis_1), .axis_2(axis_2),
    .axis_3(axis_3), .axis_4(axis_4), .axis_5(axis_5),
    .info(info)
  );

  sspd_report_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status),
    .axis_0(axis_0), .axis_1(axis_1), .axis_2(axis_2),
    .axis_3(axis_3), .axis_4(axis_4), .axis_5(axis_5),
    .info(info),
    .error_count(error_count), .pending(pending), .report_count(report_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (quiet || stall_roll < 75) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 96) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_data();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NEWLINE_BYTE);
    return b;
  endfunction

  function automatic int pick_axis();
    case ($urandom_range(0, 39))
      0: return -511;
      1: return 512;
      2: return 0;
      3: return -1;
      4: return 1;
      5: return 64;
      6: return -65;
      7: return -64;
      default: return int'($urandom_range(0, 1023)) - 511;
    endcase
  endfunction

  function automatic void random_axes();
    foreach (axis_pick[k]) axis_pick[k] = pick_axis();
  endfunction

  // Builds a displacement packet from axis_pick, optionally breaking one pair or the checksum.
  function automatic void add_motion(input logic [1:0] fault);
    logic [9:0] code;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] tail;
    logic [5:0] chk;
    int         total;
    int         adj;
    int         bad_pair;
    total = 0;
    adj = 0;
    bad_pair = $urandom_range(0, 5);
    frame.push_back(HEAD_DISP);
    for (int k = 0; k < 6; k++) begin
      code = 10'((axis_pick[k] < 0) ? axis_pick[k] + 1024 : axis_pick[k]);
      a = HI_NIBBLE_CHECK[code[9:6]] | {4'h0, code[9:6]};
      b = TOP_PAIR_CHECK[code[5:0]] | {2'b00, code[5:0]};
      if (k == bad_pair && fault == ST_BAD_A) a ^= 8'h10 << $urandom_range(0, 3);
      if (k == bad_pair && fault == ST_BAD_B) begin
        b ^= 8'h40 << $urandom_range(0, 1);
        if (b == NEWLINE_BYTE) b ^= 8'hC0;
      end
      total += axis_pick[k];
      adj += (axis_pick[k] < 0) ? -1 - ((-(axis_pick[k] + 1)) / 64) : axis_pick[k] / 64;
      frame.push_back(a);
      frame.push_back(b);
    end
    chk = total[5:0] + adj[5:0];
    if (fault == ST_CHK) chk ^= 6'($urandom_range(1, 63));
    frame.push_back(any_data());
    tail = {2'($urandom_range(0, 3)), chk};
    if (tail == NEWLINE_BYTE) tail = 8'h4A;
    frame.push_back(tail);
    frame.push_back(NEWLINE_BYTE);
  endfunction

  function automatic void add_short(input logic [7:0] head, input int len);
    frame.push_back(head);
    repeat (len - 1) frame.push_back(any_data());
    frame.push_back(NEWLINE_BYTE);
  endfunction

  task automatic send_frame();
    int gap;
    foreach (frame[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= frame[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    frame.delete();
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int         r;
    logic [7:0] head;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    frame.push_back(NEWLINE_BYTE);
    send_frame();
    axis_pick = '{512, -511, 0, -1, 64, -65};
    add_motion(ST_OK);
    send_frame();
    random_axes();
    add_motion(ST_BAD_A);
    send_frame();
    random_axes();
    add_motion(ST_BAD_B);
    send_frame();
    random_axes();
    add_motion(ST_CHK);
    send_frame();
    frame = '{HEAD_BUTTON, 8'hFF, 8'hFF, 8'hFF, NEWLINE_BYTE};
    send_frame();
    add_short(HEAD_MODE, LEN_MODE);
    send_frame();
    frame = '{HEAD_RADIUS, 8'h0F, NEWLINE_BYTE};
    send_frame();
    add_short(HEAD_SCALE, LEN_SCALE);
    send_frame();
    add_short(HEAD_DISP, 5);
    send_frame();
    repeat (8) frame.push_back(8'h00);
    repeat (8) frame.push_back(8'hFF);
    frame.push_back(NEWLINE_BYTE);
    send_frame();

    while (bytes_sent < BYTE_TARGET) begin
      if (frames_sent % 12 == 0) quiet <= ($urandom_range(0, 3) == 0);
      if (frames_sent == 40 || $urandom_range(0, 49) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        random_axes();
        if (r < 30) add_motion(ST_OK);
        else if (r % 3 == 0) add_motion(ST_BAD_A);
        else if (r % 3 == 1) add_motion(ST_BAD_B);
        else add_motion(ST_CHK);
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: add_short(HEAD_BUTTON, LEN_BUTTON);
          1: add_short(HEAD_MODE, LEN_MODE);
          2: add_short(HEAD_RADIUS, LEN_RADIUS);
          default: add_short(HEAD_SCALE, LEN_SCALE);
        endcase
      end else if (r < 78) begin
        case ($urandom_range(0, 4))
          0: head = HEAD_DISP;
          1: head = HEAD_BUTTON;
          2: head = HEAD_MODE;
          3: head = HEAD_RADIUS;
          default: head = HEAD_SCALE;
        endcase
        add_short(head, $urandom_range(1, 15));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) frame.push_back(NEWLINE_BYTE);
      end else if (r < 94) begin
        frame.push_back(NEWLINE_BYTE);
      end else begin
        repeat ($urandom_range(16, 20)) frame.push_back(any_data());
        if ($urandom_range(0, 1)) frame.push_back(NEWLINE_BYTE);
      end
      if (frame.size() > 0) send_frame();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d bytes in %0d packets and checked %0d reports.",
             bytes_sent, frames_sent, report_count);
    $display("Mix: good and corrupted displacement packets, every short packet kind, "
             , "wrong lengths, noise, empty packets and overruns.");
    if (pending != 0) $display("%0t: %0d expected reports never arrived", $time, pending);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
